/* hw/rtl/pmst_pkg.sv */
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared widths, reset values and controller/datapath interface types for the
// edge-list minimum spanning tree block.
// ----------------------------------------------------------------------------
package pmst_pkg;

	localparam int VTX_W = 6;
	localparam int WGT_W = 16;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

	typedef struct packed {
		logic load;
		logic init;
		logic scan_start;
		logic relax_start;
		logic out_start;
	} pmst_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic relax_done;
		logic out_done;
	} pmst_stat_t;

endpackage

/* hw/rtl/prim_mst_edge_list_top.sv */
// ----------------------------------------------------------------------------
// prim_mst_edge_list_top
// Minimum spanning tree over a stored edge list, grown from vertex 0.
//
// Channel   Direction  Handshake                  Payload
// edge      in         start, busy                edge_source, edge_dest,
//                                                 edge_weight, last_edge
// config    in         config_valid, config_ready config_data (vertex count)
// result    out        result_strobe              vertex_index, key_weight, reached,
//                                                 parent_vertex, has_parent, last_vertex
//
// Each start while idle loads one edge, until the edge memory is full. After the last
// edge, with R reached vertices, the block stays busy for R rounds, each a scan of
// the key memory (single read port) and a sweep of the edge memory, then one scan
// that finds nothing and a readout. V results follow on consecutive cycles, the last
// one in the cycle in which busy drops; the receiver cannot stall them.
// Reset clears control state only; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module prim_mst_edge_list_top import pmst_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [VTX_W-1:0] edge_source,
	input  logic [VTX_W-1:0] edge_dest,
	input  logic [WGT_W-1:0] edge_weight,
	input  logic             last_edge,
	input  logic             config_valid,
	output logic             config_ready,
	input  logic [CFG_W-1:0] config_data,
	output logic             result_strobe,
	output logic [VTX_W-1:0] vertex_index,
	output logic [WGT_W-1:0] key_weight,
	output logic             reached,
	output logic [VTX_W-1:0] parent_vertex,
	output logic             has_parent,
	output logic             last_vertex
);

	pmst_cmd_t  cmd;
	pmst_stat_t stat;

	pmst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_edge (last_edge),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	pmst_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.edge_source   (edge_source),
		.edge_dest     (edge_dest),
		.edge_weight   (edge_weight),
		.config_valid  (config_valid),
		.config_ready  (config_ready),
		.config_data   (config_data),
		.result_strobe (result_strobe),
		.vertex_index  (vertex_index),
		.key_weight    (key_weight),
		.reached       (reached),
		.parent_vertex (parent_vertex),
		.has_parent    (has_parent),
		.last_vertex   (last_vertex)
	);

endmodule

/* hw/rtl/pmst_ctrl.sv */
// ----------------------------------------------------------------------------
// pmst_ctrl
// Sequencer: edge loading, tree init, alternating minimum scan and edge
// relaxation rounds, then result readout.
// ----------------------------------------------------------------------------
module pmst_ctrl import pmst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       last_edge,
	input  pmst_stat_t stat,
	output pmst_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_RELAX,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   init_q;
	logic   scan_q;
	logic   relax_q;
	logic   out_q;

	assign busy = busy_q;
	assign cmd  = '{
		load:        start & ~busy_q,
		init:        init_q,
		scan_start:  scan_q,
		relax_start: relax_q,
		out_start:   out_q
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			init_q  <= 1'b0;
			scan_q  <= 1'b0;
			relax_q <= 1'b0;
			out_q   <= 1'b0;
		end else begin
			init_q  <= 1'b0;
			scan_q  <= 1'b0;
			relax_q <= 1'b0;
			out_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start && last_edge) begin
						state_q <= ST_INIT;
						busy_q  <= 1'b1;
						init_q  <= 1'b1;
					end
				end
				ST_INIT: begin
					state_q <= ST_SCAN;
					scan_q  <= 1'b1;
				end
				ST_SCAN: begin
					if (stat.scan_done) begin
						if (stat.found) begin
							state_q <= ST_RELAX;
							relax_q <= 1'b1;
						end else begin
							state_q <= ST_OUT;
							out_q   <= 1'b1;
						end
					end
				end
				ST_RELAX: begin
					if (stat.relax_done) begin
						state_q <= ST_SCAN;
						scan_q  <= 1'b1;
					end
				end
				ST_OUT: begin
					if (stat.out_done) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/pmst_dp.sv */
// ----------------------------------------------------------------------------
// pmst_dp
// Datapath: edge memory, key and parent memories, tree and finite-key flags,
// scan pipeline, two-stage relaxation pipeline and result readout.
// ----------------------------------------------------------------------------
module pmst_dp import pmst_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pmst_cmd_t        cmd,
	output pmst_stat_t       stat,
	input  logic [VTX_W-1:0] edge_source,
	input  logic [VTX_W-1:0] edge_dest,
	input  logic [WGT_W-1:0] edge_weight,
	input  logic             config_valid,
	output logic             config_ready,
	input  logic [CFG_W-1:0] config_data,
	output logic             result_strobe,
	output logic [VTX_W-1:0] vertex_index,
	output logic [WGT_W-1:0] key_weight,
	output logic             reached,
	output logic [VTX_W-1:0] parent_vertex,
	output logic             has_parent,
	output logic             last_vertex
);

	localparam int VW     = $clog2(MAX_VERTICES);
	localparam int NW     = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W  = (NW > CFG_W) ? NW : CFG_W;
	localparam int EW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW    = $clog2(MAX_EDGES + 1);
	localparam int WB     = WEIGHT_BITS;
	localparam int XW     = (WB > WGT_W) ? WB : WGT_W;
	localparam int EDGE_W = 2 * VTX_W + WB;

	// configuration and graph size
	logic [CFG_W-1:0]        vcount_q;
	logic [NW-1:0]           nv_q;
	logic [NW-1:0]           nv_last;
	logic [CMP_W-1:0]        vc_x;
	logic [CMP_W-1:0]        nv_clamp;
	logic [CMP_W-1:0]        nv_x;

	// edge list
	logic [EDGE_W-1:0]       edge_mem [MAX_EDGES];
	logic [ECW-1:0]          edge_cnt_q;
	logic                    edge_full;
	logic [XW-1:0]           wgt_x;

	// tree state
	logic [WB-1:0]           key_mem [MAX_VERTICES];
	logic [VW-1:0]           par_mem [MAX_VERTICES];
	logic [WB-1:0]           key_rd_q;
	logic [VW-1:0]           par_rd_q;
	logic [VW-1:0]           key_raddr;
	logic                    key_we;
	logic [VW-1:0]           key_waddr;
	logic [WB-1:0]           key_wdata;
	logic [MAX_VERTICES-1:0] in_tree_q;
	logic [MAX_VERTICES-1:0] kval_q;

	// scan
	logic                    scan_act_q;
	logic [NW-1:0]           scan_v_q;
	logic                    scan_vld_s1;
	logic [VW-1:0]           scan_v_s1;
	logic                    found_q;
	logic [WB-1:0]           best_q;
	logic [VW-1:0]           u_q;
	logic                    cand;

	// relaxation
	logic                    rel_act_q;
	logic [ECW-1:0]          e_q;
	logic                    rel_vld_s1;
	logic [EDGE_W-1:0]       edge_s1;
	logic                    rel_vld_s2;
	logic                    ok_s2;
	logic [VW-1:0]           other_s2;
	logic [WB-1:0]           wgt_s2;
	logic                    fwd_we_q;
	logic [VW-1:0]           fwd_addr_q;
	logic [WB-1:0]           fwd_key_q;
	logic [CMP_W-1:0]        a_x;
	logic [CMP_W-1:0]        b_x;
	logic [CMP_W-1:0]        u_x;
	logic [CMP_W-1:0]        other_x;
	logic                    hit_a;
	logic                    hit_b;
	logic                    rel_ok;
	logic [VW-1:0]           other_idx;
	logic [WB-1:0]           cur_key;
	logic                    upd;

	// readout
	logic                    out_act_q;
	logic [NW-1:0]           ov_q;
	logic                    out_vld_s1;
	logic [VW-1:0]           ov_s1;
	logic                    out_last_s1;
	logic [CMP_W-1:0]        ov_x;
	logic [CMP_W-1:0]        par_x;
	logic [XW-1:0]           key_x;

	assign config_ready = 1'b1;

	assign vc_x     = CMP_W'(vcount_q);
	assign nv_clamp = (vc_x == '0) ? CMP_W'(1) :
	                  (vc_x > CMP_W'(MAX_VERTICES)) ? CMP_W'(MAX_VERTICES) : vc_x;
	assign nv_x     = CMP_W'(nv_q);
	assign nv_last  = nv_q - NW'(1);

	assign edge_full = (edge_cnt_q == ECW'(MAX_EDGES));
	assign wgt_x     = XW'(edge_weight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (config_valid && config_ready) begin
			vcount_q <= config_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !edge_full) begin
			edge_mem[edge_cnt_q[EW-1:0]] <= {edge_source, edge_dest, wgt_x[WB-1:0]};
		end
		edge_s1 <= edge_mem[e_q[EW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
		end else if (cmd.out_start) begin
			edge_cnt_q <= '0;
		end else if (cmd.load && !edge_full) begin
			edge_cnt_q <= edge_cnt_q + ECW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			nv_q <= NW'(nv_clamp);
		end
	end

	// scan: pick the lowest finite key outside the tree
	assign cand = scan_vld_s1 && !in_tree_q[scan_v_s1] && kval_q[scan_v_s1] &&
	              (!found_q || key_rd_q < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q  <= 1'b0;
			scan_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			scan_vld_s1 <= scan_act_q;
			if (cmd.scan_start) begin
				scan_act_q <= 1'b1;
				found_q    <= 1'b0;
			end else begin
				if (scan_act_q && scan_v_q == nv_last) begin
					scan_act_q <= 1'b0;
				end
				if (cand) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_v_s1 <= scan_v_q[VW-1:0];
		if (cmd.scan_start) begin
			scan_v_q <= '0;
		end else if (scan_act_q) begin
			scan_v_q <= scan_v_q + NW'(1);
		end
		if (cand) begin
			best_q <= key_rd_q;
			u_q    <= scan_v_s1;
		end
	end

	assign stat.scan_done = scan_vld_s1 && !scan_act_q;
	assign stat.found     = found_q || cand;

	// relaxation stage 1: match the edge against the new tree vertex
	assign a_x       = CMP_W'(edge_s1[EDGE_W-1 -: VTX_W]);
	assign b_x       = CMP_W'(edge_s1[EDGE_W-VTX_W-1 -: VTX_W]);
	assign u_x       = CMP_W'(u_q);
	assign hit_a     = (a_x == u_x);
	assign hit_b     = (b_x == u_x);
	assign other_x   = hit_a ? b_x : a_x;
	assign rel_ok    = (a_x < nv_x) && (b_x < nv_x) && (hit_a || hit_b);
	assign other_idx = other_x[VW-1:0];

	// relaxation stage 2: compare against the current key, bypass last write
	assign cur_key = (fwd_we_q && fwd_addr_q == other_s2) ? fwd_key_q : key_rd_q;
	assign upd     = rel_vld_s2 && ok_s2 && !in_tree_q[other_s2] &&
	                 (!kval_q[other_s2] || wgt_s2 < cur_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_act_q  <= 1'b0;
			rel_vld_s1 <= 1'b0;
			rel_vld_s2 <= 1'b0;
			fwd_we_q   <= 1'b0;
		end else begin
			rel_vld_s1 <= rel_act_q;
			rel_vld_s2 <= rel_vld_s1;
			fwd_we_q   <= upd;
			if (cmd.relax_start) begin
				rel_act_q <= 1'b1;
			end else if (rel_act_q && e_q == edge_cnt_q - ECW'(1)) begin
				rel_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.relax_start) begin
			e_q <= '0;
		end else if (rel_act_q) begin
			e_q <= e_q + ECW'(1);
		end
		ok_s2      <= rel_ok;
		other_s2   <= other_idx;
		wgt_s2     <= edge_s1[WB-1:0];
		fwd_addr_q <= other_s2;
		fwd_key_q  <= wgt_s2;
	end

	assign stat.relax_done = rel_vld_s2 && !rel_vld_s1 && !rel_act_q;

	// tree flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tree_q <= '0;
			kval_q    <= '0;
		end else if (cmd.init) begin
			in_tree_q <= '0;
			kval_q    <= MAX_VERTICES'(1);
		end else begin
			if (cmd.relax_start) begin
				in_tree_q[u_q] <= 1'b1;
			end
			if (upd) begin
				kval_q[other_s2] <= 1'b1;
			end
		end
	end

	// key and parent memories
	assign key_we    = cmd.init || upd;
	assign key_waddr = cmd.init ? '0 : other_s2;
	assign key_wdata = cmd.init ? '0 : wgt_s2;
	assign key_raddr = scan_act_q ? scan_v_q[VW-1:0] :
	                   out_act_q  ? ov_q[VW-1:0] : other_idx;

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		key_rd_q <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			par_mem[other_s2] <= u_q;
		end
		par_rd_q <= par_mem[ov_q[VW-1:0]];
	end

	// readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_act_q  <= 1'b0;
			out_vld_s1 <= 1'b0;
		end else begin
			out_vld_s1 <= out_act_q;
			if (cmd.out_start) begin
				out_act_q <= 1'b1;
			end else if (out_act_q && ov_q == nv_last) begin
				out_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ov_s1       <= ov_q[VW-1:0];
		out_last_s1 <= (ov_q == nv_last);
		if (cmd.out_start) begin
			ov_q <= '0;
		end else if (out_act_q) begin
			ov_q <= ov_q + NW'(1);
		end
	end

	assign stat.out_done = out_act_q && (ov_q == nv_last);

	assign ov_x  = CMP_W'(ov_s1);
	assign par_x = CMP_W'(par_rd_q);
	assign key_x = XW'(key_rd_q);

	assign result_strobe = out_vld_s1;
	assign vertex_index  = ov_x[VTX_W-1:0];
	assign reached       = in_tree_q[ov_s1];
	assign has_parent    = in_tree_q[ov_s1] && (ov_s1 != '0);
	assign parent_vertex = has_parent ? par_x[VTX_W-1:0] : '0;
	assign key_weight    = reached ? key_x[WGT_W-1:0] : '0;
	assign last_vertex   = out_last_s1;

endmodule
